### rtl/ovn2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovn2d_pkg
// Shared types and fixed constants of the 2-D octave value noise block.
// ----------------------------------------------------------------------------
package ovn2d_pkg;

  localparam int LOG_GRID    = 6;                       // grid is 2**LOG_GRID square
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_OCT     = LOG_GRID + 1;
  localparam int ADDR_W      = 2 * LOG_GRID;
  localparam int PITCH_W     = LOG_GRID + 1;
  localparam int WPROD_W     = 2 * PITCH_W;
  localparam int PROD_W      = WPROD_W + SAMPLE_BITS;
  localparam int ACC_W       = SAMPLE_BITS + FRAC_BITS + MAX_OCT + 1;
  localparam int DIVD_W      = ACC_W - FRAC_BITS;
  localparam int RADIX_BITS  = 4;
  localparam int DIV_STEPS   = DIVD_W / RADIX_BITS;
  localparam int OCT_W       = 3;
  localparam int SH_W        = 5;
  localparam int SH_BASE     = FRAC_BITS - 2 * LOG_GRID - 1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

### rtl/octave_value_noise_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octave_value_noise_2d
// Seed grid in one synchronous memory; queries blend four samples per octave,
// weight the octaves and normalize through a radix-16 divider.
// ----------------------------------------------------------------------------
// Write items: an item every cycle while the block is idle (no query in flight).
// Query items: the block takes no new item from accept until the result is
//   loaded into the output register; out_tvalid rises once it is loaded. Four reads
//   per octave on the single memory read port, a pipeline drain, the divider steps
//   and an output load make up a query; a held output stalls the load.
// Reset: control state and octave_count (1) reset; the seed grid is not cleared.
// ----------------------------------------------------------------------------
module octave_value_noise_2d (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x_pos[5:0], y_pos[11:6], sample_value[27:12], zero
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // noise_value[15:0]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);
  import ovn2d_pkg::*;

  logic [SAMPLE_BITS-1:0] mem [2**ADDR_W];

  state_t                 state_r, state_nxt;
  logic [OCT_W-1:0]       octave_r;
  logic [OCT_W-1:0]       n_r, n_cfg;
  logic [LOG_GRID-1:0]    x_r, y_r;
  logic [OCT_W-1:0]       oct_r;
  logic [1:0]             corner_r;
  logic                   v1_r, v2_r;
  logic [WPROD_W-1:0]     wp1_r;
  logic [SH_W-1:0]        sh1_r, sh2_r;
  logic [PROD_W-1:0]      prod_r;
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic [ACC_W-1:0]       acc_r;
  logic [DIVD_W-1:0]      quo_r, quo_nxt;
  logic [PITCH_W:0]       rem_r, rem_nxt;
  logic [PITCH_W-1:0]     div_r;
  logic [2:0]             cnt_r;
  logic [15:0]            out_data_r;
  logic                   out_valid_r;

  logic                   in_acc, is_write, is_query, issue, last_issue, out_load;
  logic [LOG_GRID-1:0]    in_x, in_y;
  logic [PITCH_W-1:0]     pitch, wx, wy;
  logic [LOG_GRID-1:0]    mask, x1, y1, x2, y2, dx, dy, rx, ry;
  logic [ADDR_W-1:0]      rd_addr;
  logic [WPROD_W-1:0]     wprod;
  logic [15:0]            noise_sat;

  assign in_x     = in_tdata[LOG_GRID-1:0];
  assign in_y     = in_tdata[2*LOG_GRID-1:LOG_GRID];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc   = in_tvalid && in_tready;
  assign is_write = in_acc && (in_tuser == KIND_WRITE);
  assign is_query = in_acc && (in_tuser == KIND_QUERY);

  always_comb begin
    if (octave_r == '0) begin
      n_cfg = OCT_W'(1);
    end else if (octave_r > OCT_W'(MAX_OCT)) begin
      n_cfg = OCT_W'(MAX_OCT);
    end else begin
      n_cfg = octave_r;
    end
  end

  // corner addressing and bilinear weights of the current octave
  always_comb begin
    pitch = PITCH_W'(1) << (OCT_W'(LOG_GRID) - oct_r);
    mask  = LOG_GRID'(pitch - PITCH_W'(1));
    dx    = x_r & mask;
    dy    = y_r & mask;
    x1    = x_r & ~mask;
    y1    = y_r & ~mask;
    x2    = x1 + pitch[LOG_GRID-1:0];
    y2    = y1 + pitch[LOG_GRID-1:0];
    rx    = corner_r[0] ? x2 : x1;
    ry    = corner_r[1] ? y2 : y1;
    wx    = corner_r[0] ? PITCH_W'(dx) : pitch - PITCH_W'(dx);
    wy    = corner_r[1] ? PITCH_W'(dy) : pitch - PITCH_W'(dy);
    wprod = WPROD_W'(wx) * WPROD_W'(wy);
    rd_addr = {ry, rx};
  end

  assign issue      = (state_r == S_READ);
  assign last_issue = issue && (corner_r == 2'd3) && ((oct_r + OCT_W'(1)) == n_r);

  // seed memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (is_write) begin
      mem[{in_y, in_x}] <= SAMPLE_BITS'(in_tdata[2*LOG_GRID +: 16]);
    end
    rd_data_r <= mem[rd_addr];
  end

  // radix-16 restoring division step
  always_comb begin
    logic [PITCH_W:0]  r;
    logic [DIVD_W-1:0] q;
    r = rem_r;
    q = quo_r;
    for (int i = 0; i < RADIX_BITS; i++) begin
      r = {r[PITCH_W-1:0], q[DIVD_W-1]};
      q = {q[DIVD_W-2:0], 1'b0};
      if (r >= {1'b0, div_r}) begin
        r    = r - {1'b0, div_r};
        q[0] = 1'b1;
      end
    end
    rem_nxt = r;
    quo_nxt = q;
  end

  assign noise_sat = (|quo_r[DIVD_W-1:16]) ? 16'hFFFF : quo_r[15:0];
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (is_query) state_nxt = S_READ;
      S_READ:  if (last_issue) state_nxt = S_DRAIN;
      S_DRAIN: if (!v1_r && !v2_r) state_nxt = S_DIV;
      S_DIV:   if (cnt_r == 3'(DIV_STEPS - 1)) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      octave_r    <= OCT_W'(1);
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        octave_r <= cfg_wdata;
      end
      v1_r <= issue;
      v2_r <= v1_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wp1_r  <= wprod;
    sh1_r  <= SH_W'(SH_BASE) + SH_W'(oct_r) + SH_W'(n_r);
    sh2_r  <= sh1_r;
    prod_r <= PROD_W'(rd_data_r) * PROD_W'(wp1_r);
    if (is_query) begin
      x_r      <= in_x;
      y_r      <= in_y;
      n_r      <= n_cfg;
      oct_r    <= '0;
      corner_r <= '0;
      acc_r    <= '0;
    end else begin
      if (issue) begin
        corner_r <= corner_r + 2'd1;
        if (corner_r == 2'd3) begin
          oct_r <= oct_r + OCT_W'(1);
        end
      end
      if (v2_r) begin
        acc_r <= acc_r + (ACC_W'(prod_r) << sh2_r);
      end
    end
    if (state_r == S_DRAIN) begin
      quo_r <= acc_r[ACC_W-1:FRAC_BITS];
      rem_r <= '0;
      div_r <= PITCH_W'((8'd1 << n_r) - 8'd1);
      cnt_r <= '0;
    end else if (state_r == S_DIV) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 3'd1;
    end
    if (out_load) begin
      out_data_r <= noise_sat;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### dv/octave_value_noise_2d_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// octave_value_noise_2d_tb
// Loads seed samples into the noise block and queries it over the stream
// ports. A shadow grid and octave count predict every noise result, and the
// results are compared in order. Before a query, every grid corner that the
// query reads is loaded. Both sides idle at random. One phase holds off the
// output for a long stretch, and one phase drains the block in mid-stream.
// ----------------------------------------------------------------------------
module octave_value_noise_2d_tb;
  import ovn2d_pkg::*;

  localparam int GRID         = 1 << LOG_GRID;
  localparam int CELLS        = GRID * GRID;
  localparam int TARGET_ITEMS = 1300;
  localparam int PHASE_ITEMS  = 100;
  localparam int QUIET_FROM   = 1100;
  localparam int SETTLE       = 4 * MAX_OCT + 12;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 2000;

  class noise_scoreboard;
    logic [15:0] seed_grid [CELLS];
    int unsigned octaves;
    logic [15:0] pending_noise [$];
    int failures;
    int checked;

    function new();
      foreach (seed_grid[i]) seed_grid[i] = '0;
      octaves  = 1;
      failures = 0;
      checked  = 0;
    endfunction

    function int active_octaves();
      int n;
      n = (octaves == 0) ? 1 : octaves;
      if (n > MAX_OCT) n = MAX_OCT;
      return n;
    endfunction

    // k selects the corner: bit 0 far column, bit 1 far row
    function int corner_index(logic [5:0] x, logic [5:0] y, int o, int k);
      int p, x1, y1, col, row;
      p   = GRID >> o;
      x1  = (x / p) * p;
      y1  = (y / p) * p;
      col = (k & 1) ? (x1 + p) % GRID : x1;
      row = (k & 2) ? (y1 + p) % GRID : y1;
      return row * GRID + col;
    endfunction

    function logic [15:0] predict_noise(logic [5:0] x, logic [5:0] y);
      int n;
      longint unsigned p, dx, dy, wx, wy, num, acc, res;
      n   = active_octaves();
      acc = 0;
      for (int o = 0; o < n; o++) begin
        p   = GRID >> o;
        dx  = x % p;
        dy  = y % p;
        num = 0;
        for (int k = 0; k < 4; k++) begin
          wx  = (k & 1) ? dx : p - dx;
          wy  = (k & 2) ? dy : p - dy;
          num += wx * wy * seed_grid[corner_index(x, y, o, k)];
        end
        acc += ((num << FRAC_BITS) / (p * p)) << (n - 1 - o);
      end
      res = acc / (((64'd1 << n) - 1) << FRAC_BITS);
      if (res > 65535) res = 65535;
      return res[15:0];
    endfunction

    function void note_item(logic kind, logic [5:0] x, logic [5:0] y, logic [15:0] v);
      if (kind == KIND_WRITE) begin
        seed_grid[{y, x}] = v;
      end else begin
        pending_noise.push_back(predict_noise(x, y));
      end
    endfunction

    function void check_noise(logic [15:0] got);
      logic [15:0] want;
      checked++;
      if (pending_noise.size() == 0) begin
        failures++;
        if (failures <= 10) $display("[%0t] noise %h with no query pending", $time, got);
      end else begin
        want = pending_noise.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10)
            $display("[%0t] noise mismatch: expected %h, got %h", $time, want, got);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_wdata = '0;

  noise_scoreboard sb;
  bit       loaded [CELLS];
  bit       src_idle = 1'b0;
  bit       sink_idle = 1'b0;
  bit       hold_sink = 1'b0;
  bit [7:0] used_oct = '0;
  int       items_sent = 0;
  int       writes = 0;
  int       queries = 0;
  int       plan [10] = '{7, 1, 4, 0, 7, 2, 5, 3, 6, 7};

  octave_value_noise_2d u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) sb.octaves = cfg_wdata;
      if (in_tvalid && in_tready)
        sb.note_item(in_tuser, in_tdata[5:0], in_tdata[11:6], in_tdata[27:12]);
      if (out_tvalid && out_tready) sb.check_noise(out_tdata);
    end
  end

  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stalled = 0;
      else stalled++;
    end
    $display("octave_value_noise_2d_tb failed");
    $finish;
  end

  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_sink = 1'b0;
      end else if (sink_idle && $urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [5:0] rand_pos();
    logic [5:0] edges [4] = '{6'd0, 6'd63, 6'd31, 6'd32};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 3)];
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic send_item(input logic kind, input logic [5:0] x, input logic [5:0] y,
                           input logic [15:0] v);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    if (kind == KIND_WRITE) begin
      loaded[{y, x}] = 1'b1;
      writes++;
    end else begin
      queries++;
    end
    in_tvalid = 1'b1;
    in_tuser  = kind;
    in_tdata  = {4'b0, v, y, x};
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
    in_tvalid = 1'b0;
    items_sent++;
  endtask

  task automatic query_at(input logic [5:0] x, input logic [5:0] y);
    int idx;
    for (int o = 0; o < sb.active_octaves(); o++) begin
      for (int k = 0; k < 4; k++) begin
        idx = sb.corner_index(x, y, o, k);
        if (!loaded[idx]) send_item(KIND_WRITE, idx[5:0], idx[11:6], rand_sample());
      end
    end
    send_item(KIND_QUERY, x, y, 16'($urandom));
  endtask

  task automatic wait_drained();
    while (sb.pending_noise.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_octaves(input logic [2:0] v);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
    used_oct[v] = 1'b1;
  endtask

  initial begin
    int  ph;
    int  start;
    bit  quiet;
    bit  paused;
    sb = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    used_oct[1] = 1'b1;

    send_item(KIND_WRITE, 6'd0, 6'd0, 16'hFFFF);
    send_item(KIND_QUERY, 6'd0, 6'd0, 16'h0000);
    send_item(KIND_QUERY, 6'd63, 6'd63, 16'hFFFF);
    send_item(KIND_QUERY, 6'd63, 6'd0, 16'h0000);
    send_item(KIND_QUERY, 6'd0, 6'd63, 16'hFFFF);
    send_item(KIND_WRITE, 6'd0, 6'd0, 16'h0000);
    send_item(KIND_QUERY, 6'd32, 6'd17, 16'hFFFF);
    send_item(KIND_WRITE, 6'd63, 6'd63, 16'hFFFF);
    set_octaves(3'd0);
    query_at(6'd5, 6'd9);
    set_octaves(3'd3);
    query_at(6'd0, 6'd0);
    query_at(6'd63, 6'd63);
    query_at(6'd17, 6'd40);

    ph = 0;
    while (items_sent < TARGET_ITEMS) begin
      quiet = items_sent >= QUIET_FROM;
      set_octaves(3'(ph < 10 ? plan[ph] : int'($urandom_range(0, 7))));
      src_idle  = !quiet && ($urandom_range(0, 3) != 0);
      sink_idle = !quiet && ($urandom_range(0, 3) != 0);
      // hold off the sink so the block backs up and stalls its input
      if (ph == 1) hold_sink = 1'b1;
      paused = 1'b0;
      start  = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        if (ph == 3 && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 6) query_at(rand_pos(), rand_pos());
        else send_item(KIND_WRITE, rand_pos(), rand_pos(), rand_sample());
      end
      ph++;
    end

    wait_drained();
    $display("covered %0d seed writes and %0d noise queries, %0d results checked",
             writes, queries, sb.checked);
    $display("octave settings used (bit per value 7..0): %b", used_oct);
    if (sb.failures == 0) begin
      $display("octave_value_noise_2d_tb passed");
    end else begin
      $display("octave_value_noise_2d_tb failed");
    end
    $finish;
  end

endmodule
